/* hdl/selective_repeat_arq_controller_unit_assert.svh */
// Assertion macros for the selective-repeat ARQ controller datapath.
`ifndef SELECTIVE_REPEAT_ARQ_CONTROLLER_UNIT_ASSERT_SVH
`define SELECTIVE_REPEAT_ARQ_CONTROLLER_UNIT_ASSERT_SVH

`ifndef SYNTH
// Invariant checked at every clock edge outside reset
`define SRARQ_ASSERT(lbl, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("srarq invariant violated");
// Condition in one cycle implies a consequence in the next
`define SRARQ_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("srarq sequencing violated");
`else
`define SRARQ_ASSERT(lbl, expr)
`define SRARQ_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

/* hdl/srarq_pkg.sv */
// Types, constants and helpers for the selective-repeat ARQ controller.
`timescale 1ns / 1ps

package srarq_pkg;

    localparam int SEQ_W       = 5;
    localparam int SLOT_W      = 4;
    localparam int LEN_W       = 9;
    localparam int PER_W       = 16;
    localparam int ACT_W       = 3;
    localparam int KIND_W      = 2;
    localparam int CMD_W       = 3;
    localparam int WIN         = 16;
    localparam int RES_CNT_W   = 6;
    localparam int LOOP_CNT_W  = 5;
    localparam int CFG_IDX_W   = 1;

    localparam logic [LEN_W-1:0] HDR_CRC_BYTES = 9'd7;
    localparam logic [LEN_W-1:0] MIN_FRAME     = 9'd5;
    localparam logic [LEN_W-1:0] PACKET_BYTES  = 9'd256;
    localparam logic [RES_CNT_W-1:0] CMD_LIMIT = 6'd33;
    localparam logic [LOOP_CNT_W-1:0] LOOP_MAX = 5'd16;
    localparam logic [SEQ_W-1:0] WIN_SEQ       = 5'd16;
    localparam logic [SEQ_W-1:0] OUT_SAT       = 5'd31;

    localparam logic [PER_W-1:0] DATA_TIMER_RESET = 16'd3600;
    localparam logic [PER_W-1:0] ACK_TIMER_RESET  = 16'd700;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DATA_TIMER = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ACK_TIMER  = 1'd1;

    // event codes
    localparam logic [ACT_W-1:0] ACT_NET_READY    = 3'd0;
    localparam logic [ACT_W-1:0] ACT_PHY_READY    = 3'd1;
    localparam logic [ACT_W-1:0] ACT_FRAME        = 3'd2;
    localparam logic [ACT_W-1:0] ACT_ACK_TIMEOUT  = 3'd3;
    localparam logic [ACT_W-1:0] ACT_DATA_TIMEOUT = 3'd4;

    // received frame kinds
    localparam logic [KIND_W-1:0] KIND_DATA = 2'd0;
    localparam logic [KIND_W-1:0] KIND_NAK  = 2'd2;

    // result command codes
    localparam logic [CMD_W-1:0] CMD_STATUS     = 3'd0;
    localparam logic [CMD_W-1:0] CMD_FETCH      = 3'd1;
    localparam logic [CMD_W-1:0] CMD_SEND_DATA  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_SEND_NAK   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_SEND_ACK   = 3'd4;
    localparam logic [CMD_W-1:0] CMD_START_ACK  = 3'd5;
    localparam logic [CMD_W-1:0] CMD_DELIVER    = 3'd6;
    localparam logic [CMD_W-1:0] CMD_STOP_TIMER = 3'd7;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_FETCH,
        S_SEND_NEW,
        S_NAK_BAD,
        S_RX_FIRST,
        S_DELIVER,
        S_RESEND,
        S_STOP,
        S_ACK,
        S_TOUT,
        S_STATUS
    } state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_CAPTURE,
        OP_PHY,
        OP_FETCH,
        OP_SEND_NEW,
        OP_NAK,
        OP_RX_FIRST,
        OP_DELIVER,
        OP_RESEND,
        OP_STOP,
        OP_ACK,
        OP_TOUT,
        OP_STATUS
    } op_t;

    typedef struct packed {
        op_t  op;
        logic cnt_clr;
    } ctrl_cmd_t;

    typedef struct packed {
        logic              out_free;
        logic [ACT_W-1:0]  action;
        logic [KIND_W-1:0] kind;
        logic              bad_frame;
        logic              nak_allowed;
        logic              send_room;
        logic              rx_store;
        logic              deliver_ok;
        logic              resend_ok;
        logic              stop_ok;
    } dp_status_t;

    // b lies in the circular interval [a, c)
    function automatic logic in_window(input logic [SEQ_W-1:0] a,
                                       input logic [SEQ_W-1:0] b,
                                       input logic [SEQ_W-1:0] c);
        in_window = ((a <= b) && (b < c)) || ((c < a) && (a <= b)) ||
                    ((b < c) && (c < a));
    endfunction

endpackage

/* hdl/srarq_ctrl.sv */
// Sequencer for the selective-repeat ARQ controller: walks each event's command run.
`timescale 1ns / 1ps

module srarq_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  srarq_pkg::dp_status_t  status,
    output srarq_pkg::ctrl_cmd_t   cmd
);
    import srarq_pkg::*;

    state_t state_reg;
    state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                    state_next = S_DECODE;
            end
            S_DECODE:
            begin
                unique case (status.action)
                    ACT_NET_READY:
                        state_next = status.send_room ? S_FETCH : S_STATUS;
                    ACT_FRAME:
                    begin
                        if (status.bad_frame)
                            state_next = status.nak_allowed ? S_NAK_BAD : S_STATUS;
                        else if (status.kind == KIND_DATA)
                            state_next = S_RX_FIRST;
                        else if (status.kind == KIND_NAK)
                            state_next = S_RESEND;
                        else
                            state_next = S_STOP;
                    end
                    ACT_ACK_TIMEOUT:  state_next = S_ACK;
                    ACT_DATA_TIMEOUT: state_next = S_TOUT;
                    default:          state_next = S_STATUS;
                endcase
            end
            S_FETCH:
            begin
                if (status.out_free)
                    state_next = S_SEND_NEW;
            end
            S_SEND_NEW, S_NAK_BAD, S_ACK, S_TOUT:
            begin
                if (status.out_free)
                    state_next = S_STATUS;
            end
            S_RX_FIRST:
            begin
                if (status.out_free)
                    state_next = status.rx_store ? S_DELIVER : S_STOP;
            end
            S_DELIVER:
            begin
                if (!status.deliver_ok)
                    state_next = S_STOP;
            end
            S_RESEND:
            begin
                if (!status.resend_ok || status.out_free)
                    state_next = S_STOP;
            end
            S_STOP:
            begin
                if (!status.stop_ok)
                    state_next = S_STATUS;
            end
            S_STATUS:
            begin
                if (status.out_free)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // command outputs
    always_comb
    begin
        s_tready    = 1'b0;
        cmd.op      = OP_NONE;
        cmd.cnt_clr = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                    cmd.op = OP_CAPTURE;
            end
            S_DECODE:
            begin
                cmd.cnt_clr = 1'b1;
                if (status.action == ACT_PHY_READY)
                    cmd.op = OP_PHY;
            end
            S_FETCH:    if (status.out_free) cmd.op = OP_FETCH;
            S_SEND_NEW: if (status.out_free) cmd.op = OP_SEND_NEW;
            S_NAK_BAD:  if (status.out_free) cmd.op = OP_NAK;
            S_RX_FIRST: if (status.out_free) cmd.op = OP_RX_FIRST;
            S_DELIVER:
            begin
                if (!status.deliver_ok)
                    cmd.cnt_clr = 1'b1;
                else if (status.out_free)
                    cmd.op = OP_DELIVER;
            end
            S_RESEND:
            begin
                if (status.resend_ok && status.out_free)
                    cmd.op = OP_RESEND;
            end
            S_STOP:
            begin
                if (status.stop_ok && status.out_free)
                    cmd.op = OP_STOP;
            end
            S_ACK:      if (status.out_free) cmd.op = OP_ACK;
            S_TOUT:     if (status.out_free) cmd.op = OP_TOUT;
            S_STATUS:   if (status.out_free) cmd.op = OP_STATUS;
            default:    cmd.op = OP_NONE;
        endcase
    end

endmodule

/* hdl/srarq_dp.sv */
// Datapath of the selective-repeat ARQ controller: window state, slot store, result register.
`timescale 1ns / 1ps
`include "selective_repeat_arq_controller_unit_assert.svh"

module srarq_dp (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [srarq_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [srarq_pkg::PER_W-1:0]     cfg_data,
    input  logic [4:0]                      s_tuser,
    input  logic [23:0]                     s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [2:0]                      m_tuser,
    output logic [39:0]                     m_tdata,
    output logic                            m_tlast,
    input  srarq_pkg::ctrl_cmd_t            cmd,
    output srarq_pkg::dp_status_t           status
);
    import srarq_pkg::*;

    // configuration
    logic [PER_W-1:0] data_period_reg;
    logic [PER_W-1:0] ack_period_reg;

    // captured input word
    logic [ACT_W-1:0]  action_reg;
    logic [KIND_W-1:0] kind_reg;
    logic [SEQ_W-1:0]  fseq_reg;
    logic [SEQ_W-1:0]  fack_reg;
    logic [LEN_W-1:0]  flen_reg;
    logic              crc_reg;
    logic [SLOT_W-1:0] tslot_reg;

    // window state
    logic [SEQ_W-1:0]      send_next_reg, send_next_next;
    logic [SEQ_W-1:0]      send_base_reg, send_base_next;
    logic [SEQ_W-1:0]      recv_base_reg, recv_base_next;
    logic [SEQ_W-1:0]      recv_limit_reg, recv_limit_next;
    logic [SEQ_W-1:0]      outstanding_reg, outstanding_next;
    logic                  phy_ready_reg, phy_ready_next;
    logic                  nak_allowed_reg, nak_allowed_next;
    logic [WIN-1:0]        arrived_reg, arrived_next;
    logic [LEN_W-1:0]      slot_length_reg [WIN];
    logic                  len_we;
    logic [LOOP_CNT_W-1:0] loop_cnt_reg, loop_cnt_next;
    logic [RES_CNT_W-1:0]  res_cnt_reg, res_cnt_next;

    // result register
    logic              out_valid_reg, out_valid_next;
    logic [CMD_W-1:0]  o_cmd_reg;
    logic [SEQ_W-1:0]  o_seq_reg;
    logic [SEQ_W-1:0]  o_ack_reg;
    logic [SLOT_W-1:0] o_slot_reg;
    logic [LEN_W-1:0]  o_len_reg;
    logic [PER_W-1:0]  o_per_reg;
    logic              o_ne_reg;
    logic              o_last_reg;

    // word being emitted this cycle
    logic              emit;
    logic              load;
    logic [CMD_W-1:0]  e_cmd;
    logic [SEQ_W-1:0]  e_seq;
    logic [SEQ_W-1:0]  e_ack;
    logic [SLOT_W-1:0] e_slot;
    logic [LEN_W-1:0]  e_len;
    logic [PER_W-1:0]  e_per;
    logic              e_ne;
    logic              e_last;

    // helpers
    logic [SEQ_W-1:0]  ack_fld;
    logic [SEQ_W-1:0]  resend_seq;
    logic [SEQ_W-1:0]  tout_seq;
    logic [LEN_W-1:0]  stored_len;
    logic [LEN_W-1:0]  deliver_len;
    logic              out_free;

    assign ack_fld    = recv_base_reg - 5'd1;
    assign resend_seq = fack_reg + 5'd1;
    assign tout_seq   = in_window(send_base_reg, {1'b0, tslot_reg}, send_next_reg) ?
                        {1'b0, tslot_reg} : {1'b1, tslot_reg};
    assign stored_len = slot_length_reg[recv_base_reg[SLOT_W-1:0]];
    assign out_free   = !out_valid_reg || m_tready;

    // delivered length: strip header and crc, cap at one packet
    always_comb
    begin
        if (stored_len < HDR_CRC_BYTES)
            deliver_len = '0;
        else if ((stored_len - HDR_CRC_BYTES) > PACKET_BYTES)
            deliver_len = PACKET_BYTES;
        else
            deliver_len = stored_len - HDR_CRC_BYTES;
    end

    // status toward the sequencer
    always_comb
    begin
        status.out_free    = out_free;
        status.action      = action_reg;
        status.kind        = kind_reg;
        status.bad_frame   = (flen_reg < MIN_FRAME) || !crc_reg;
        status.nak_allowed = nak_allowed_reg;
        status.send_room   = outstanding_reg < WIN_SEQ;
        status.rx_store    = in_window(recv_base_reg, fseq_reg, recv_limit_reg) &&
                             !arrived_reg[fseq_reg[SLOT_W-1:0]];
        status.deliver_ok  = arrived_reg[recv_base_reg[SLOT_W-1:0]] &&
                             (loop_cnt_reg < LOOP_MAX);
        status.resend_ok   = in_window(send_base_reg, resend_seq, send_next_reg);
        status.stop_ok     = (loop_cnt_reg < LOOP_MAX) &&
                             in_window(send_base_reg, fack_reg, send_next_reg);
    end

    // micro-operations
    always_comb
    begin
        send_next_next   = send_next_reg;
        send_base_next   = send_base_reg;
        recv_base_next   = recv_base_reg;
        recv_limit_next  = recv_limit_reg;
        outstanding_next = outstanding_reg;
        phy_ready_next   = phy_ready_reg;
        nak_allowed_next = nak_allowed_reg;
        arrived_next     = arrived_reg;
        loop_cnt_next    = loop_cnt_reg;
        res_cnt_next     = res_cnt_reg;
        len_we           = 1'b0;
        emit             = 1'b0;
        e_cmd            = CMD_STATUS;
        e_seq            = '0;
        e_ack            = '0;
        e_slot           = '0;
        e_len            = '0;
        e_per            = '0;
        e_ne             = 1'b0;
        e_last           = 1'b0;
        case (cmd.op)
            OP_CAPTURE:
            begin
                res_cnt_next = '0;
            end
            OP_PHY:
            begin
                phy_ready_next = 1'b1;
            end
            OP_FETCH:
            begin
                emit   = 1'b1;
                e_cmd  = CMD_FETCH;
                e_seq  = send_next_reg;
                e_slot = send_next_reg[SLOT_W-1:0];
            end
            OP_SEND_NEW:
            begin
                emit           = 1'b1;
                e_cmd          = CMD_SEND_DATA;
                e_seq          = send_next_reg;
                e_ack          = ack_fld;
                e_slot         = send_next_reg[SLOT_W-1:0];
                e_per          = data_period_reg;
                phy_ready_next = 1'b0;
                send_next_next = send_next_reg + 5'd1;
                if (outstanding_reg < OUT_SAT)
                    outstanding_next = outstanding_reg + 5'd1;
            end
            OP_NAK:
            begin
                emit             = 1'b1;
                e_cmd            = CMD_SEND_NAK;
                e_ack            = ack_fld;
                phy_ready_next   = 1'b0;
                nak_allowed_next = 1'b0;
            end
            OP_RX_FIRST:
            begin
                emit = 1'b1;
                if ((fseq_reg != recv_base_reg) && nak_allowed_reg)
                begin
                    e_cmd            = CMD_SEND_NAK;
                    e_ack            = ack_fld;
                    phy_ready_next   = 1'b0;
                    nak_allowed_next = 1'b0;
                end
                else
                begin
                    e_cmd = CMD_START_ACK;
                    e_per = ack_period_reg;
                end
                if (status.rx_store)
                begin
                    arrived_next[fseq_reg[SLOT_W-1:0]] = 1'b1;
                    len_we = 1'b1;
                end
            end
            OP_DELIVER:
            begin
                emit             = 1'b1;
                e_cmd            = CMD_DELIVER;
                e_slot           = recv_base_reg[SLOT_W-1:0];
                e_len            = deliver_len;
                nak_allowed_next = 1'b1;
                arrived_next[recv_base_reg[SLOT_W-1:0]] = 1'b0;
                recv_base_next   = recv_base_reg + 5'd1;
                recv_limit_next  = recv_limit_reg + 5'd1;
                loop_cnt_next    = loop_cnt_reg + 5'd1;
            end
            OP_RESEND:
            begin
                emit           = 1'b1;
                e_cmd          = CMD_SEND_DATA;
                e_seq          = resend_seq;
                e_ack          = ack_fld;
                e_slot         = resend_seq[SLOT_W-1:0];
                e_per          = data_period_reg;
                phy_ready_next = 1'b0;
            end
            OP_STOP:
            begin
                emit           = 1'b1;
                e_cmd          = CMD_STOP_TIMER;
                e_slot         = send_base_reg[SLOT_W-1:0];
                send_base_next = send_base_reg + 5'd1;
                loop_cnt_next  = loop_cnt_reg + 5'd1;
                if (outstanding_reg != '0)
                    outstanding_next = outstanding_reg - 5'd1;
            end
            OP_ACK:
            begin
                emit           = 1'b1;
                e_cmd          = CMD_SEND_ACK;
                e_ack          = ack_fld;
                phy_ready_next = 1'b0;
            end
            OP_TOUT:
            begin
                emit           = 1'b1;
                e_cmd          = CMD_SEND_DATA;
                e_seq          = tout_seq;
                e_ack          = ack_fld;
                e_slot         = tout_seq[SLOT_W-1:0];
                e_per          = data_period_reg;
                phy_ready_next = 1'b0;
            end
            OP_STATUS:
            begin
                emit   = 1'b1;
                e_cmd  = CMD_STATUS;
                e_ne   = (outstanding_reg < WIN_SEQ) && phy_ready_reg;
                e_last = 1'b1;
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase

        if (cmd.cnt_clr)
            loop_cnt_next = '0;

        // commands past the result limit are dropped; the status always goes out
        load = emit && (e_last || (res_cnt_reg < CMD_LIMIT));
        if (load)
            res_cnt_next = res_cnt_reg + 6'd1;

        out_valid_next = out_valid_reg;
        if (load)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            data_period_reg <= DATA_TIMER_RESET;
            ack_period_reg  <= ACK_TIMER_RESET;
            send_next_reg   <= '0;
            send_base_reg   <= '0;
            recv_base_reg   <= '0;
            recv_limit_reg  <= WIN_SEQ;
            outstanding_reg <= '0;
            phy_ready_reg   <= 1'b0;
            nak_allowed_reg <= 1'b1;
            arrived_reg     <= '0;
            loop_cnt_reg    <= '0;
            res_cnt_reg     <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we && (cfg_index == REG_DATA_TIMER))
                data_period_reg <= cfg_data;
            if (cfg_we && (cfg_index == REG_ACK_TIMER))
                ack_period_reg <= cfg_data;
            send_next_reg   <= send_next_next;
            send_base_reg   <= send_base_next;
            recv_base_reg   <= recv_base_next;
            recv_limit_reg  <= recv_limit_next;
            outstanding_reg <= outstanding_next;
            phy_ready_reg   <= phy_ready_next;
            nak_allowed_reg <= nak_allowed_next;
            arrived_reg     <= arrived_next;
            loop_cnt_reg    <= loop_cnt_next;
            res_cnt_reg     <= res_cnt_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // payload registers: input capture, slot lengths, result word
    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_CAPTURE)
        begin
            action_reg <= s_tuser[2:0];
            kind_reg   <= s_tuser[4:3];
            fseq_reg   <= s_tdata[4:0];
            fack_reg   <= s_tdata[9:5];
            flen_reg   <= s_tdata[18:10];
            crc_reg    <= s_tdata[19];
            tslot_reg  <= s_tdata[23:20];
        end
        if (len_we)
            slot_length_reg[fseq_reg[SLOT_W-1:0]] <= flen_reg;
        if (load)
        begin
            o_cmd_reg  <= e_cmd;
            o_seq_reg  <= e_seq;
            o_ack_reg  <= e_ack;
            o_slot_reg <= e_slot;
            o_len_reg  <= e_len;
            o_per_reg  <= e_per;
            o_ne_reg   <= e_ne;
            o_last_reg <= e_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = o_cmd_reg;
    assign m_tdata  = {o_ne_reg, o_per_reg, o_len_reg, o_slot_reg, o_ack_reg, o_seq_reg};
    assign m_tlast  = o_last_reg;

    // checks
    `SRARQ_ASSERT(a_outstanding_bound, outstanding_reg <= WIN_SEQ)
    `SRARQ_ASSERT(a_outstanding_span, outstanding_reg == (send_next_reg - send_base_reg))
    `SRARQ_ASSERT(a_recv_window, recv_limit_reg == (recv_base_reg + WIN_SEQ))
    `SRARQ_ASSERT_NEXT(a_status_counted, load && e_last, res_cnt_reg <= 6'd34)

endmodule

/* hdl/selective_repeat_arq_controller_unit.sv */
// After an event is accepted, the sequencer decodes it and then registers its first result word.
// Each event gives up to 34 result words, at one per cycle while the output is ready; the next
// event is accepted only once the sequencer is back in idle, and it emits into a single
// result register. Reset (rst_n low, async): windows cleared, arrival map cleared at once,
// timer periods 3600 and 700; slot lengths are not reset and need no clearing pass.
`timescale 1ns / 1ps

module selective_repeat_arq_controller_unit (
    input  logic        clk,
    input  logic        rst_n,
    // configuration write port
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [15:0] cfg_data,
    // event input
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [4:0]  s_tuser,   // action[2:0], frame_kind[4:3]
    input  logic [23:0] s_tdata,   // frame_seq[4:0], piggyback_ack[9:5], frame_length[18:10],
                                   // crc_good[19], timer_slot[23:20]
    // command output
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [2:0]  m_tuser,   // command[2:0]
    output logic [39:0] m_tdata,   // seq_number[4:0], ack_number[9:5], slot[13:10],
                                   // payload_length[22:14], timer_period[38:23],
                                   // network_enable[39]
    output logic        m_tlast
);
    import srarq_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    srarq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    srarq_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tuser   (m_tuser),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cmd       (cmd),
        .status    (status)
    );

endmodule
